FILE: hw/rtl/native_contact_fraction_top_assert.svh
// Assertion macros shared by ncf_back and the top module.
`ifndef NATIVE_CONTACT_FRACTION_TOP_ASSERT_SVH
`define NATIVE_CONTACT_FRACTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NCF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NCF_ASSERT_IMP(label, clk, rst, ante, cons)
`define NCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/ncf_pkg.sv
package ncf_pkg;
  localparam int COORD_W = 24;
  localparam int D2_W = 50;
  localparam int SUM_W = 29;
  localparam int FRAC_W = 18;
  localparam int CNT_W = 13;
  localparam int NT_W = 13;
  localparam int IN_W = 6 * COORD_W + 2 * D2_W;

  typedef struct packed {
    logic [D2_W-1:0] r2;
    logic [D2_W-1:0] nat;
    logic            formed;
    logic            partial;
    logic            last;
  } job_t;
endpackage

FILE: hw/rtl/ncf_front.sv
module ncf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ncf_pkg::IN_W-1:0]     in_data,
  input  logic                         in_last,
  output logic                         job_valid,
  input  logic                         job_ready,
  output ncf_pkg::job_t                job
);
  localparam int CW = ncf_pkg::COORD_W;
  localparam int DW = ncf_pkg::D2_W;
  localparam int MW = CW + 1;

  logic              busy;
  logic [1:0]        phase;
  logic [2*MW-1:0]   acc;
  logic [MW-1:0]     dm [3];
  logic [DW-1:0]     nat;
  logic [DW-1:0]     cut;
  logic              last;
  logic signed [MW-1:0] d [3];
  logic [DW-1:0]     r2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = MW'(signed'(in_data[i*CW +: CW])) - MW'(signed'(in_data[(i+3)*CW +: CW]));
    end
  end

  assign in_ready = !busy;
  assign r2 = DW'(acc);
  assign job_valid = busy && (phase == 2'd3);
  assign job.r2 = r2;
  assign job.nat = nat;
  assign job.formed = r2 < nat;
  assign job.partial = !(r2 < nat) && (r2 < cut);
  assign job.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 2'd0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        phase <= 2'd0;
        acc <= '0;
        for (int i = 0; i < 3; i++) begin
          dm[i] <= d[i][MW-1] ? MW'(-d[i]) : MW'(d[i]);
        end
        nat <= in_data[6*CW +: DW];
        cut <= in_data[6*CW+DW +: DW];
        last <= in_last;
      end
    end else if (phase != 2'd3) begin
      acc <= acc + dm[phase] * dm[phase];
      phase <= phase + 2'd1;
    end else if (job_ready) begin
      busy <= 1'b0;
    end
  end
endmodule

FILE: hw/rtl/ncf_fifo.sv
module ncf_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ncf_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ncf_pkg::job_t rd_job
);
  ncf_pkg::job_t mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_job;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      count <= count + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
    end
  end
endmodule

FILE: hw/rtl/ncf_back.sv
`include "native_contact_fraction_top_assert.svh"
module ncf_back #(
  parameter int MAX_CONTACTS = 4096,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ncf_pkg::NT_W-1:0]   native_total,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  ncf_pkg::job_t              job,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ncf_pkg::FRAC_W-1:0] out_fraction,
  output logic [ncf_pkg::CNT_W-1:0]  out_count,
  output logic                       out_sat
);
  localparam int DW = ncf_pkg::D2_W;
  localparam int SW = ncf_pkg::SUM_W;
  localparam int CW = ncf_pkg::CNT_W;
  localparam int FB = RATIO_FRAC_BITS;
  localparam int PW = FB + 1;
  localparam int CAP = (MAX_CONTACTS < 8191) ? MAX_CONTACTS : 8191;
  localparam int QW = SW;
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_SQ2 = 4'd2, S_SQ3 = 4'd3,
    S_SQ6 = 4'd4, S_ADD = 4'd5, S_NDIV = 4'd6, S_OUT = 4'd7;

  logic [3:0]      state;
  logic [5:0]      cnt;
  logic [DW:0]     rem;
  logic [DW-1:0]   r2;
  logic [PW-1:0]   s;
  logic [PW-1:0]   s2;
  logic [PW-1:0]   s3;
  logic [PW-1:0]   s6;
  logic [SW-1:0]   contact_sum;
  logic [CW-1:0]   formed_total;
  logic            last;
  logic [SW:0]     addend;
  logic [SW+PW:0]  sum_wide;
  logic [SW-1:0]   nrem;
  logic [QW-1:0]   quo;
  logic [SW-1:0]   num;
  logic [ncf_pkg::NT_W-1:0] nt;
  logic [DW:0]     rem_sh;
  logic [SW:0]     nrem_sh;
  logic [2*PW-1:0] prod;
  logic [PW-1:0]   pa;
  logic [PW-1:0]   pb;

  assign rem_sh = {rem[DW-1:0], 1'b0};
  assign nrem_sh = {nrem, num[SW-1]};
  assign job_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign nt = (native_total == '0) ? ncf_pkg::NT_W'(1) : native_total;
  assign prod = pa * pb;

  always_comb begin
    pa = s;
    pb = s;
    case (state)
      S_SQ3: begin pa = s2; pb = s; end
      S_SQ6: begin pa = s3; pb = s3; end
      default: begin pa = s; pb = s; end
    endcase
  end

  always_comb begin
    addend = (SW+1)'(2 * {1'b0, s3}) - (SW+1)'(s6);
    sum_wide = (SW+PW+1)'(contact_sum) + (SW+PW+1)'(addend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      contact_sum <= '0;
      formed_total <= '0;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            last <= job.last;
            r2 <= job.r2;
            rem <= (DW+1)'(job.nat);
            cnt <= '0;
            if (job.formed) begin
              if (formed_total < CW'(CAP)) formed_total <= formed_total + 1'b1;
              s <= PW'(1) << FB;
              s3 <= PW'(0);
              s6 <= PW'(0);
              contact_sum <= ((SW+1)'(contact_sum) + (SW+1)'(1 << FB) > (SW+1)'({SW{1'b1}}))
                ? {SW{1'b1}} : SW'((SW+1)'(contact_sum) + (SW+1)'(1 << FB));
              state <= S_ADD;
            end else if (job.partial && job.r2 != '0) begin
              state <= (job.nat >= job.r2) ? S_SQ2 : S_DIV;
              s <= (job.nat >= job.r2) ? (PW'(1) << FB) : '0;
            end else begin
              s <= '0;
              s3 <= '0;
              s6 <= '0;
              state <= S_ADD;
            end
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, r2}) begin
            rem <= rem_sh - {1'b0, r2};
            s <= {s[PW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            s <= {s[PW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(FB - 1)) state <= S_SQ2;
        end
        S_SQ2: begin s2 <= PW'(prod >> FB); state <= S_SQ3; end
        S_SQ3: begin s3 <= PW'(prod >> FB); state <= S_SQ6; end
        S_SQ6: begin
          s6 <= PW'(prod >> FB);
          s <= '0;
          state <= S_ADD;
        end
        S_ADD: begin
          if (s == '0) begin
            contact_sum <= (sum_wide > (SW+PW+1)'({SW{1'b1}})) ? {SW{1'b1}} : SW'(sum_wide);
          end
          if (last) begin
            num <= (s == '0) ? ((sum_wide > (SW+PW+1)'({SW{1'b1}})) ? {SW{1'b1}} : SW'(sum_wide))
                             : contact_sum;
            nrem <= '0;
            quo <= '0;
            cnt <= '0;
            state <= S_NDIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_NDIV: begin
          num <= {num[SW-2:0], 1'b0};
          if (nrem_sh >= (SW+1)'(nt)) begin
            nrem <= SW'(nrem_sh - (SW+1)'(nt));
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            nrem <= SW'(nrem_sh);
            quo <= {quo[QW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(SW - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            contact_sum <= '0;
            formed_total <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_sat = quo > QW'({ncf_pkg::FRAC_W{1'b1}});
  assign out_fraction = out_sat ? {ncf_pkg::FRAC_W{1'b1}} : ncf_pkg::FRAC_W'(quo);
  assign out_count = formed_total;

  `NCF_ASSERT_IMP(a_ready_idle, clk, rst, job_ready, !out_valid)
  `NCF_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, formed_total <= CW'(CAP))
  `NCF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(quo))
endmodule

FILE: hw/rtl/native_contact_fraction_top.sv
// Channel  Dir  Contents
// s_axis   in   tdata: first_x..z, second_x..z, native_d2, cutoff_d2; tlast: last_contact
// m_axis   out  tdata: fraction, formed_count; tuser: saturated
// cfg      in   native_total write
// The front takes one contact at a time: it captures it, sums the axis squares (one per
// axis), then holds r2 until the queue takes it.
// The back adds a contact beyond cutoff or fully formed at once; a partial one first
// takes a 16-step ratio division and three multiplies. The last adds a 29-step divide.
// A two-entry queue parts front and back, so each stalls on its own.
// Reset is synchronous and sets native_total to 1 and clears the sums.
`include "native_contact_fraction_top_assert.svh"
module native_contact_fraction_top #(
  parameter int MAX_CONTACTS = 4096,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, native_d2, cutoff_d2
  input  logic [247:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fraction, formed_count, zero fill
  output logic [31:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         cfg_we,
  input  logic [12:0]  cfg_wdata
);
  logic [12:0]   native_total;
  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  ncf_pkg::job_t fj, bj;
  logic [17:0]   fr;
  logic [12:0]   fc;

  always_ff @(posedge clk) begin
    if (rst) native_total <= 13'd1;
    else if (cfg_we) native_total <= cfg_wdata;
  end

  ncf_front u_front (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[ncf_pkg::IN_W-1:0]), .in_last(s_axis_tlast),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

  ncf_fifo u_fifo (.clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj));

  ncf_back #(.MAX_CONTACTS(MAX_CONTACTS), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_back (
    .clk, .rst, .native_total, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_fraction(fr),
    .out_count(fc), .out_sat(m_axis_tuser));

  assign m_axis_tdata = {1'b0, fc, fr};

  `NCF_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[31] == 1'b0)
  `NCF_ASSERT_IMP(a_sat_max, clk, rst, m_axis_tvalid && m_axis_tuser, fr == 18'h3ffff)
  `NCF_ASSERT_NEXT(a_cfg, clk, rst, cfg_we, native_total == $past(cfg_wdata))
endmodule
